[sv/mbrot_pkg.sv]
// Shared types, constants and helpers for the escape-time pixel evaluator.
package mbrot_pkg;

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 27;
    localparam int ITER_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int GRAY_BITS  = 8;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;

    localparam logic signed [DATA_W-1:0] RST_ORIGIN_RE = -32'sd281857229;
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_IM = -32'sd161061274;
    localparam logic signed [DATA_W-1:0] RST_STEP_RE   = 32'sd67109;
    localparam logic signed [DATA_W-1:0] RST_STEP_IM   = 32'sd67109;
    localparam logic [ITER_BITS-1:0]     RST_MAX_ITER  = 16'd500;

    localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(1) << (2 * FRAC_BITS + 2);

    // Four times 255 squared: the root test works on (2r - 1) squared.
    localparam logic [DATA_W-1:0] GRAY_RHS_SCALE = 32'd260100;
    localparam int RHS_W = ITER_BITS + 18;

    localparam logic signed [PROD_W-1:0] DATA_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] DATA_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_re;
        logic signed [DATA_W-1:0] origin_im;
        logic signed [DATA_W-1:0] step_re;
        logic signed [DATA_W-1:0] step_im;
        logic [ITER_BITS-1:0]     max_iter;
    } t_cfg;

    typedef enum logic [2:0] {
        MUL_COL_STEP = 3'd0,
        MUL_ROW_STEP = 3'd1,
        MUL_RE_RE    = 3'd2,
        MUL_IM_IM    = 3'd3,
        MUL_RE_IM    = 3'd4,
        MUL_COUNT    = 3'd5,
        MUL_DSQ      = 3'd6,
        MUL_LIMIT    = 3'd7
    } t_mul_op;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > DATA_MAX) begin
            r = DATA_MAX[DATA_W-1:0];
        end else if (v < DATA_MIN) begin
            r = DATA_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[sv/mbrot_cfg.sv]
// Configuration register file with reset defaults.
module mbrot_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mbrot_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbrot_pkg::DATA_W-1:0]     i_cfg_data,
    output mbrot_pkg::t_cfg                  o_cfg
);

    mbrot_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_re <= mbrot_pkg::RST_ORIGIN_RE;
            r_cfg.origin_im <= mbrot_pkg::RST_ORIGIN_IM;
            r_cfg.step_re   <= mbrot_pkg::RST_STEP_RE;
            r_cfg.step_im   <= mbrot_pkg::RST_STEP_IM;
            r_cfg.max_iter  <= mbrot_pkg::RST_MAX_ITER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbrot_pkg::REG_ORIGIN_RE: r_cfg.origin_re <= $signed(i_cfg_data);
                mbrot_pkg::REG_ORIGIN_IM: r_cfg.origin_im <= $signed(i_cfg_data);
                mbrot_pkg::REG_STEP_RE:   r_cfg.step_re   <= $signed(i_cfg_data);
                mbrot_pkg::REG_STEP_IM:   r_cfg.step_im   <= $signed(i_cfg_data);
                mbrot_pkg::REG_MAX_ITER:  r_cfg.max_iter  <= i_cfg_data[mbrot_pkg::ITER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/mbrot_mul.sv]
// Shared signed multiplier with its operand selection.
module mbrot_mul (
    input  mbrot_pkg::t_mul_op                   i_op,
    input  mbrot_pkg::t_cfg                      i_cfg,
    input  logic signed [mbrot_pkg::DATA_W-1:0]  i_re,
    input  logic signed [mbrot_pkg::DATA_W-1:0]  i_im,
    input  logic [mbrot_pkg::COORD_BITS-1:0]     i_row,
    input  logic [mbrot_pkg::COORD_BITS-1:0]     i_col,
    input  logic [mbrot_pkg::ITER_BITS-1:0]      i_count,
    input  logic [mbrot_pkg::DATA_W-1:0]         i_aux,
    output logic signed [mbrot_pkg::PROD_W-1:0]  o_prod
);

    logic signed [mbrot_pkg::DATA_W-1:0] w_a;
    logic signed [mbrot_pkg::DATA_W-1:0] w_b;

    always_comb begin
        case (i_op)
            mbrot_pkg::MUL_COL_STEP: begin
                w_a = $signed(mbrot_pkg::DATA_W'(i_col));
                w_b = i_cfg.step_re;
            end
            mbrot_pkg::MUL_ROW_STEP: begin
                w_a = $signed(mbrot_pkg::DATA_W'(i_row));
                w_b = i_cfg.step_im;
            end
            mbrot_pkg::MUL_RE_RE: begin
                w_a = i_re;
                w_b = i_re;
            end
            mbrot_pkg::MUL_IM_IM: begin
                w_a = i_im;
                w_b = i_im;
            end
            mbrot_pkg::MUL_RE_IM: begin
                w_a = i_re;
                w_b = i_im;
            end
            mbrot_pkg::MUL_COUNT: begin
                w_a = $signed(mbrot_pkg::DATA_W'(i_count));
                w_b = $signed(mbrot_pkg::GRAY_RHS_SCALE);
            end
            mbrot_pkg::MUL_DSQ: begin
                w_a = $signed(i_aux);
                w_b = $signed(i_aux);
            end
            mbrot_pkg::MUL_LIMIT: begin
                w_a = $signed(i_aux);
                w_b = $signed(mbrot_pkg::DATA_W'(i_cfg.max_iter));
            end
            default: begin
                w_a = i_re;
                w_b = i_re;
            end
        endcase
    end

    assign o_prod = mbrot_pkg::PROD_W'(w_a) * mbrot_pkg::PROD_W'(w_b);

endmodule

[sv/mandelbrot_escape_time_pixel.sv]
// Escape-time pixel evaluator: sequencer around one shared multiplier.
//
//  channel   signals                                   direction
//  command   i_start, o_busy, i_row, i_col             in (o_busy out)
//  result    o_done, o_gray, o_iterations, o_in_set    out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data           in
//
// Setup steps through S_CRE, S_CIM and S_CLD, then each iteration steps through
// S_SQRE, S_SQIM, S_CROSS and S_UPD because the one multiplier forms re*re, im*im
// and re*im in turn. A point in the set ends in S_SQRE when the count hits max_iter;
// a point that escapes then runs the gray root search in S_RHS, S_RSQ and S_RLIM.
// The result beat is shown for one cycle on o_done, in the cycle busy falls.
// Reset is synchronous and restores the register defaults; the receiver cannot stall.
module mandelbrot_escape_time_pixel (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [mbrot_pkg::COORD_BITS-1:0]   i_row,
    input  logic [mbrot_pkg::COORD_BITS-1:0]   i_col,
    output logic                               o_done,
    output logic [mbrot_pkg::GRAY_BITS-1:0]    o_gray,
    output logic [mbrot_pkg::ITER_BITS-1:0]    o_iterations,
    output logic                               o_in_set,
    input  logic                               i_cfg_we,
    input  logic [mbrot_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mbrot_pkg::DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CRE   = 11'b000_0000_0010,
        S_CIM   = 11'b000_0000_0100,
        S_CLD   = 11'b000_0000_1000,
        S_SQRE  = 11'b000_0001_0000,
        S_SQIM  = 11'b000_0010_0000,
        S_CROSS = 11'b000_0100_0000,
        S_UPD   = 11'b000_1000_0000,
        S_RHS   = 11'b001_0000_0000,
        S_RSQ   = 11'b010_0000_0000,
        S_RLIM  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    mbrot_pkg::t_cfg    w_cfg;
    mbrot_pkg::t_mul_op w_op;
    logic signed [mbrot_pkg::PROD_W-1:0] w_prod;
    logic [mbrot_pkg::DATA_W-1:0]        w_aux;

    logic [mbrot_pkg::COORD_BITS-1:0]    r_row;
    logic [mbrot_pkg::COORD_BITS-1:0]    r_col;
    logic signed [mbrot_pkg::PROD_W-1:0] r_prod;
    logic signed [mbrot_pkg::PROD_W-1:0] r_acc;
    logic signed [mbrot_pkg::DATA_W-1:0] r_c_re;
    logic signed [mbrot_pkg::DATA_W-1:0] r_c_im;
    logic signed [mbrot_pkg::DATA_W-1:0] r_re;
    logic signed [mbrot_pkg::DATA_W-1:0] r_im;
    logic                                r_esc;
    logic [mbrot_pkg::ITER_BITS-1:0]     r_t;
    logic [mbrot_pkg::RHS_W-1:0]         r_rhs;
    logic [mbrot_pkg::GRAY_BITS-1:0]     r_g;
    logic [2:0]                          r_bit;
    logic                                r_done;
    logic [mbrot_pkg::GRAY_BITS-1:0]     r_gray;
    logic [mbrot_pkg::ITER_BITS-1:0]     r_iter;
    logic                                r_in_set;

    logic [mbrot_pkg::GRAY_BITS-1:0]     w_trial;
    logic [mbrot_pkg::GRAY_BITS:0]       w_d;
    logic                                w_fit;
    logic [mbrot_pkg::GRAY_BITS-1:0]     w_g_next;
    logic signed [mbrot_pkg::PROD_W-1:0] w_c_re_sum;
    logic signed [mbrot_pkg::PROD_W-1:0] w_c_im_sum;
    logic signed [mbrot_pkg::PROD_W-1:0] w_re_sum;
    logic signed [mbrot_pkg::PROD_W-1:0] w_im_sum;
    logic [mbrot_pkg::PROD_W-1:0]        w_mag;
    logic                                w_at_limit;

    mbrot_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    mbrot_mul u_mul (
        .i_op    (w_op),
        .i_cfg   (w_cfg),
        .i_re    (r_re),
        .i_im    (r_im),
        .i_row   (r_row),
        .i_col   (r_col),
        .i_count (r_t),
        .i_aux   (w_aux),
        .o_prod  (w_prod)
    );

    assign w_trial    = r_g | (mbrot_pkg::GRAY_BITS'(1) << r_bit);
    assign w_d        = {w_trial, 1'b0} - (mbrot_pkg::GRAY_BITS + 1)'(1);
    assign w_fit      = $unsigned(w_prod) <= mbrot_pkg::PROD_W'(r_rhs);
    assign w_g_next   = w_fit ? w_trial : r_g;
    assign w_c_re_sum = mbrot_pkg::PROD_W'(w_cfg.origin_re) + r_prod;
    assign w_c_im_sum = mbrot_pkg::PROD_W'(w_cfg.origin_im) + r_prod;
    assign w_re_sum   = (r_acc >>> mbrot_pkg::FRAC_BITS) + mbrot_pkg::PROD_W'(r_c_re);
    assign w_im_sum   = (r_prod >>> (mbrot_pkg::FRAC_BITS - 1)) + mbrot_pkg::PROD_W'(r_c_im);
    assign w_mag      = $unsigned(r_acc) + $unsigned(r_prod);
    assign w_at_limit = (r_t == w_cfg.max_iter);

    always_comb begin
        w_aux = '0;
        case (r_state)
            S_CRE:   w_op = mbrot_pkg::MUL_COL_STEP;
            S_CIM:   w_op = mbrot_pkg::MUL_ROW_STEP;
            S_SQRE:  w_op = mbrot_pkg::MUL_RE_RE;
            S_SQIM:  w_op = mbrot_pkg::MUL_IM_IM;
            S_CROSS: w_op = mbrot_pkg::MUL_RE_IM;
            S_RHS:   w_op = mbrot_pkg::MUL_COUNT;
            S_RSQ: begin
                w_op  = mbrot_pkg::MUL_DSQ;
                w_aux = mbrot_pkg::DATA_W'(w_d);
            end
            S_RLIM: begin
                w_op  = mbrot_pkg::MUL_LIMIT;
                w_aux = r_prod[mbrot_pkg::DATA_W-1:0];
            end
            default: w_op = mbrot_pkg::MUL_RE_RE;
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_start ? S_CRE : S_IDLE;
            S_CRE:   n_state = S_CIM;
            S_CIM:   n_state = S_CLD;
            S_CLD:   n_state = S_SQRE;
            S_SQRE:  n_state = w_at_limit ? S_IDLE : S_SQIM;
            S_SQIM:  n_state = S_CROSS;
            S_CROSS: n_state = S_UPD;
            S_UPD:   n_state = r_esc ? S_RHS : S_SQRE;
            S_RHS:   n_state = S_RSQ;
            S_RSQ:   n_state = S_RLIM;
            S_RLIM:  n_state = (r_bit == 3'd0) ? S_IDLE : S_RSQ;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_row <= i_row;
                        r_col <= i_col;
                        r_t   <= '0;
                    end
                end
                S_CRE: begin
                    r_prod <= w_prod;
                end
                S_CIM: begin
                    r_c_re <= mbrot_pkg::sat_data(w_c_re_sum);
                    r_re   <= mbrot_pkg::sat_data(w_c_re_sum);
                    r_prod <= w_prod;
                end
                S_CLD: begin
                    r_c_im <= mbrot_pkg::sat_data(w_c_im_sum);
                    r_im   <= mbrot_pkg::sat_data(w_c_im_sum);
                end
                S_SQRE: begin
                    if (w_at_limit) begin
                        r_gray   <= '0;
                        r_iter   <= r_t;
                        r_in_set <= 1'b1;
                        r_done   <= 1'b1;
                    end else begin
                        r_prod <= w_prod;
                    end
                end
                S_SQIM: begin
                    r_acc  <= r_prod;
                    r_prod <= w_prod;
                end
                S_CROSS: begin
                    r_esc  <= w_mag > mbrot_pkg::MAG_LIMIT;
                    r_acc  <= r_acc - r_prod;
                    r_prod <= w_prod;
                end
                S_UPD: begin
                    if (!r_esc) begin
                        r_re <= mbrot_pkg::sat_data(w_re_sum);
                        r_im <= mbrot_pkg::sat_data(w_im_sum);
                        r_t  <= r_t + mbrot_pkg::ITER_BITS'(1);
                    end
                end
                S_RHS: begin
                    r_rhs <= w_prod[mbrot_pkg::RHS_W-1:0];
                    r_g   <= '0;
                    r_bit <= 3'd7;
                end
                S_RSQ: begin
                    r_prod <= w_prod;
                end
                S_RLIM: begin
                    r_g   <= w_g_next;
                    r_bit <= r_bit - 3'd1;
                    if (r_bit == 3'd0) begin
                        r_gray   <= w_g_next;
                        r_iter   <= r_t;
                        r_in_set <= 1'b0;
                        r_done   <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_gray       = r_gray;
    assign o_iterations = r_iter;
    assign o_in_set     = r_in_set;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result beat shown while busy");

    a_set_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_in_set) |-> (o_gray == '0))
        else $error("in-set point has nonzero gray");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat lasted more than one cycle");

endmodule
